[sv/kopt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kopt_pkg: shared types and constants
// Command and status codes, the request and result records, and the engine
// states used by the key owner permission table.
// ----------------------------------------------------------------------------
package kopt_pkg;

  localparam int TABLE_DEPTH = 32;

  // Depth of the request queue and of the result queue.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR      = 2'd0,
    CMD_REGISTER   = 2'd1,
    CMD_UNREGISTER = 2'd2,
    CMD_CHECK      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_TABLE_FULL = 2'd1,
    STATUS_NOT_FOUND  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_MATCH,
    ENG_APPLY
  } eng_state_e;

  typedef struct packed {
    cmd_e               op;
    logic        [15:0] key_id;
    logic signed [31:0] owner_id;
  } req_t;

  typedef struct packed {
    logic    permitted;
    status_e status;
  } result_t;

endpackage : kopt_pkg
`default_nettype wire

[sv/key_owner_permission_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_owner_permission_table: key handle / owner partition table
// Queue-style front accepts clear, register, unregister and check requests;
// a table engine executes them; results leave through a result queue.
//
//   channel   handshake         payload
//   request   push / full       command, key_id, owner_id
//   result    empty / pop       permitted, status
//
// The engine takes each request through load, a compare of all entries in
// parallel, then priority pick and table update, and takes no new request
// until the current one has pushed its result.
// Reset clears the table at once; there is no clearing pass.
// A stalled result consumer fills the result queue and then the request
// queue before full rises.
// ----------------------------------------------------------------------------
module key_owner_permission_table (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic        [1:0]  command,
  input  wire logic        [15:0] key_id,
  input  wire logic signed [31:0] owner_id,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    permitted,
  output logic             [1:0]  status
);
  import kopt_pkg::*;

  logic    req_valid;
  req_t    req;
  logic    req_pop;
  logic    res_full;
  logic    res_push;
  result_t res;

  kopt_req_queue u_req_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .key_id    (key_id),
    .owner_id  (owner_id),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  kopt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  kopt_res_queue u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full),
    .empty     (empty),
    .pop       (pop),
    .permitted (permitted),
    .status    (status)
  );

endmodule : key_owner_permission_table
`default_nettype wire

[sv/kopt_req_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kopt_req_queue: front end
// Accepts requests, decodes the command field and holds the decoded requests
// in a short queue until the table engine takes them.
// ----------------------------------------------------------------------------
module kopt_req_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic        [1:0]  command,
  input  wire logic        [15:0] key_id,
  input  wire logic signed [31:0] owner_id,
  output logic                    req_valid,
  output kopt_pkg::req_t          req,
  input  wire logic               req_pop
);
  import kopt_pkg::*;

  req_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;
  req_t               decoded;

  always_comb begin
    decoded          = '0;
    decoded.op       = cmd_e'(command);
    decoded.key_id   = key_id;
    decoded.owner_id = owner_id;
  end

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign req_valid = (count != '0);
  assign req       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = req_pop && req_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  a_req_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("request queue holds more than its depth");

endmodule : kopt_req_queue
`default_nettype wire

[sv/kopt_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kopt_engine: back end
// Holds the table of (handle, partition) pairs and carries out one request
// at a time: a compare pass over all entries, then a priority pick and update.
// ----------------------------------------------------------------------------
module kopt_engine (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  input  wire kopt_pkg::req_t  req,
  output logic                 req_pop,
  input  wire logic            res_full,
  output logic                 res_push,
  output kopt_pkg::result_t    res
);
  import kopt_pkg::*;

  logic        [15:0]      entry_handle    [TABLE_DEPTH];
  logic signed [31:0]      entry_partition [TABLE_DEPTH];

  eng_state_e              state;
  eng_state_e              state_next;
  req_t                    cur;
  logic [TABLE_DEPTH-1:0]  match;
  logic [TABLE_DEPTH-1:0]  match_next;
  logic [TABLE_DEPTH-1:0]  pick;
  logic                    hit;
  logic                    load;
  logic                    apply;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    apply      = 1'b0;
    unique case (state)
      ENG_IDLE: begin
        // Start only when the result has somewhere to go.
        if (req_valid && !res_full) begin
          load       = 1'b1;
          state_next = ENG_MATCH;
        end
      end
      ENG_MATCH: begin
        state_next = ENG_APPLY;
      end
      ENG_APPLY: begin
        apply      = 1'b1;
        state_next = ENG_IDLE;
      end
      default: begin
        state_next = ENG_IDLE;
      end
    endcase
  end

  assign req_pop  = load;
  assign res_push = apply;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= req;
    end
  end

  // Every entry is compared against the request at once; which test counts
  // depends on the command.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      unique case (cur.op)
        CMD_REGISTER:
          match_next[i] = (entry_handle[i] == 16'd0) && (entry_partition[i] == 32'sd0);
        CMD_UNREGISTER:
          match_next[i] = (entry_handle[i] == cur.key_id);
        CMD_CHECK:
          match_next[i] = (entry_handle[i] == cur.key_id) &&
                          (entry_partition[i] == cur.owner_id);
        default:
          match_next[i] = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ENG_MATCH) begin
      match <= match_next;
    end
  end

  // Lowest set bit of the match vector wins.
  assign pick = match & (~match + TABLE_DEPTH'(1));
  assign hit  = |match;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        entry_handle[i]    <= '0;
        entry_partition[i] <= '0;
      end
    end else if (apply) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if ((cur.op == CMD_CLEAR) || ((cur.op == CMD_UNREGISTER) && pick[i])) begin
          entry_handle[i]    <= '0;
          entry_partition[i] <= '0;
        end else if ((cur.op == CMD_REGISTER) && pick[i]) begin
          entry_handle[i]    <= cur.key_id;
          entry_partition[i] <= cur.owner_id;
        end
      end
    end
  end

  always_comb begin
    res.permitted = (cur.op == CMD_CHECK) && hit;
    if ((cur.op == CMD_REGISTER) && !hit) begin
      res.status = STATUS_TABLE_FULL;
    end else if ((cur.op == CMD_UNREGISTER) && !hit) begin
      res.status = STATUS_NOT_FOUND;
    end else begin
      res.status = STATUS_OK;
    end
  end

  a_pick_onehot : assert property (@(posedge clk) disable iff (rst)
    (state == ENG_APPLY) |-> $onehot0(pick))
    else $error("priority pick selected more than one entry");

  a_clear_zeroes : assert property (@(posedge clk) disable iff (rst)
    (apply && (cur.op == CMD_CLEAR)) |=>
      (entry_handle[0] == 16'd0) && (entry_partition[0] == 32'sd0))
    else $error("clear left the first entry nonzero");

  a_push_has_room : assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

endmodule : kopt_engine
`default_nettype wire

[sv/kopt_res_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kopt_res_queue: result queue
// Holds finished results until the consumer pops them, so the engine can
// move on while a result waits.
// ----------------------------------------------------------------------------
module kopt_res_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_push,
  input  wire kopt_pkg::result_t res,
  output logic                   res_full,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   permitted,
  output logic [1:0]             status
);
  import kopt_pkg::*;

  result_t            slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;
  result_t            head;

  assign res_full  = (count == Q_CNT_W'(Q_DEPTH));
  assign empty     = (count == '0);
  assign do_push   = res_push && !res_full;
  assign do_pop    = pop && !empty;
  assign head      = slots[rd_ptr];
  assign permitted = head.permitted;
  assign status    = head.status;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule : kopt_res_queue
`default_nettype wire

[verif/tb_key_owner_permission_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_owner_permission_table: self-checking bench for the permission table
// Drives clear, register, unregister and check requests through the queue
// front end. A scoreboard keeps a shadow copy of the table and predicts each
// result. Accepted results are compared field by field against the
// predictions, in order. Both sides idle at random, and in one phase the
// result side holds off long enough for full to rise.
// ----------------------------------------------------------------------------
module tb_key_owner_permission_table;
  import kopt_pkg::*;

  localparam int CLK_HALF_NS  = 6;
  localparam int TIMEOUT_NS   = 3_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 12;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               push         = 1'b0;
  logic               pop          = 1'b0;
  logic        [1:0]  command      = CMD_CLEAR;
  logic        [15:0] key_id       = '0;
  logic signed [31:0] owner_id     = '0;
  logic               full;
  logic               empty;
  logic               permitted;
  logic        [1:0]  status;

  // Set while a phase runs with no idling on either side.
  logic no_gaps   = 1'b0;
  // The main sequence bumps this to make the result side hold off.
  int   hold_asks = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  class permission_tracker;
    logic [15:0] slot_handle[TABLE_DEPTH];
    logic [31:0] slot_partition[TABLE_DEPTH];
    result_t     pending_results[$];
    int          mismatch_count;

    function new();
      mismatch_count = 0;
      wipe_slots();
    endfunction

    function void wipe_slots();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_handle[i]    = '0;
        slot_partition[i] = '0;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Applies one accepted request to the shadow table and queues its result.
    task note_request(cmd_e op, logic [15:0] handle, logic [31:0] part);
      result_t want;
      int      idx;
      want.permitted = 1'b0;
      want.status    = STATUS_OK;
      idx = -1;
      case (op)
        CMD_CLEAR: begin
          wipe_slots();
        end
        CMD_REGISTER: begin
          // A slot holding the zero pair counts as free.
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (idx < 0 && slot_handle[i] == '0 && slot_partition[i] == '0) idx = i;
          if (idx < 0) begin
            want.status = STATUS_TABLE_FULL;
          end else begin
            slot_handle[idx]    = handle;
            slot_partition[idx] = part;
          end
        end
        CMD_UNREGISTER: begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (idx < 0 && slot_handle[i] == handle) idx = i;
          if (idx < 0) begin
            want.status = STATUS_NOT_FOUND;
          end else begin
            slot_handle[idx]    = '0;
            slot_partition[idx] = '0;
          end
        end
        default: begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot_handle[i] == handle && slot_partition[i] == part) want.permitted = 1'b1;
        end
      endcase
      pending_results.push_back(want);
    endtask

    task check_result(logic got_permitted, logic [1:0] got_status);
      result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (got_permitted !== want.permitted)
        report_mismatch($sformatf("permitted %b, expected %b", got_permitted, want.permitted));
      if (got_status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
    endtask
  endclass

  permission_tracker tracker = new();

  key_owner_permission_table dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .key_id    (key_id),
    .owner_id  (owner_id),
    .empty     (empty),
    .pop       (pop),
    .permitted (permitted),
    .status    (status)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) tracker.note_request(cmd_e'(command), key_id, owner_id);
      if (pop && !empty) tracker.check_result(permitted, status);
    end
  end

  // Result side: random idling, plus a long hold-off counted here when asked.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      pop       <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= no_gaps || ($urandom_range(99) >= 28);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_request(input cmd_e op, input logic [15:0] handle,
                              input logic [31:0] part);
    command  <= op;
    key_id   <= handle;
    owner_id <= part;
    push     <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if (!no_gaps) begin
      while ($urandom_range(99) < 28) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // The first edge lets the scoreboard note the last accepted request.
  task automatic wait_all_results();
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // Small pools make checks and unregisters hit entries that are present.
  function automatic logic [15:0] pick_handle();
    if ($urandom_range(99) >= 70) return 16'($urandom);
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'h00A5;
      3:       return 16'h8000;
      4:       return 16'hFFFF;
      default: return 16'h1234;
    endcase
  endfunction

  function automatic logic [31:0] pick_partition();
    if ($urandom_range(99) >= 70) return $urandom;
    case ($urandom_range(3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic run_random(input int n_items, input int clear_w, input int reg_w);
    int   roll;
    cmd_e op;
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      if (roll < clear_w)                                    op = CMD_CLEAR;
      else if (roll < clear_w + reg_w)                       op = CMD_REGISTER;
      else if (roll < clear_w + reg_w + (100 - clear_w - reg_w) / 2) op = CMD_UNREGISTER;
      else                                                   op = CMD_CHECK;
      send_request(op, pick_handle(), pick_partition());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table: the zero pair looks free, and unregister of zero finds it.
    send_request(CMD_CHECK,      16'h0000, 32'h0000_0000);
    send_request(CMD_UNREGISTER, 16'h1234, 32'h0000_0000);
    send_request(CMD_UNREGISTER, 16'h0000, 32'h0000_0000);
    send_request(CMD_REGISTER,   16'hFFFF, 32'h7FFF_FFFF);
    send_request(CMD_REGISTER,   16'h0001, 32'h8000_0000);
    send_request(CMD_REGISTER,   16'h0001, 32'h8000_0000);
    send_request(CMD_REGISTER,   16'h0000, 32'h0000_0000);
    send_request(CMD_CHECK,      16'hFFFF, 32'h7FFF_FFFF);
    send_request(CMD_CHECK,      16'hFFFF, 32'h8000_0000);
    send_request(CMD_CHECK,      16'h0001, 32'h8000_0000);
    // Duplicate pairs: each unregister removes only the first copy.
    send_request(CMD_UNREGISTER, 16'h0001, 32'h0000_0000);
    send_request(CMD_CHECK,      16'h0001, 32'h8000_0000);
    send_request(CMD_UNREGISTER, 16'h0001, 32'hFFFF_FFFF);
    send_request(CMD_CHECK,      16'h0001, 32'h8000_0000);
    send_request(CMD_REGISTER,   16'h0000, 32'hFFFF_FFFF);
    send_request(CMD_UNREGISTER, 16'h0000, 32'h0000_0000);
    send_request(CMD_CHECK,      16'h0000, 32'hFFFF_FFFF);
    send_request(CMD_CLEAR,      16'hFFFF, 32'hFFFF_FFFF);
    send_request(CMD_CHECK,      16'hFFFF, 32'h7FFF_FFFF);
    push <= 1'b0;
    wait_all_results();

    // Fill the table while results are held back, so full must rise and the
    // last registers find no free slot.
    no_gaps   <= 1'b1;
    hold_asks <= hold_asks + 1;
    for (int k = 0; k < TABLE_DEPTH + 3; k++)
      send_request(CMD_REGISTER, 16'($urandom) | 16'h0001, $urandom);
    send_request(CMD_CHECK,      16'h0000, 32'h0000_0000);
    send_request(CMD_UNREGISTER, 16'h0000, 32'h0000_0000);
    push    <= 1'b0;
    no_gaps <= 1'b0;
    wait_all_results();

    run_random(200, 2, 45);
    push <= 1'b0;
    wait_all_results();
    run_random(200, 1, 70);
    push <= 1'b0;
    wait_all_results();
    no_gaps <= 1'b1;
    run_random(150, 2, 30);
    push    <= 1'b0;
    no_gaps <= 1'b0;
    wait_all_results();
    run_random(150, 3, 50);
    push <= 1'b0;
    wait_all_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.outstanding() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[key_owner_permission_table.f]
sv/kopt_pkg.sv
sv/kopt_req_queue.sv
sv/kopt_engine.sv
sv/kopt_res_queue.sv
sv/key_owner_permission_table.sv
verif/tb_key_owner_permission_table.sv
